/* rtl/usbsx_pkg.sv */
package usbsx_pkg;

    // Code index values from the low nibble of the packet header
    localparam logic [3:0] CODE_MASK      = 4'hF;
    localparam logic [3:0] CODE_CONTINUE  = 4'h4;
    localparam logic [3:0] CODE_END_ONE   = 4'h5;
    localparam logic [3:0] CODE_END_TWO   = 4'h6;
    localparam logic [3:0] CODE_END_THREE = 4'h7;

    // Special MIDI bytes
    localparam logic [7:0] BYTE_START = 8'hF0;
    localparam logic [7:0] BYTE_MAKER = 8'h7D;
    localparam logic [7:0] BYTE_END   = 8'hF7;

    // Result kinds
    localparam logic KIND_DATA     = 1'b0;
    localparam logic KIND_COMPLETE = 1'b1;

    localparam int MAX_RESULTS = 4;

    typedef struct packed {
        logic [7:0] packet_header;
        logic [7:0] payload_first;
        logic [7:0] payload_second;
        logic [7:0] payload_third;
    } t_packet;

    typedef struct packed {
        logic       kind;
        logic [6:0] data_byte;
        logic [8:0] position;
        logic [9:0] message_length;
        logic       last;
    } t_result;

    // All results caused by one packet, in order, and how many there are
    typedef struct packed {
        t_result [MAX_RESULTS-1:0] res;
        logic [2:0]                n_res;
    } t_batch;

endpackage

/* rtl/usbsx_stream_if.sv */
interface usbsx_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/usbsx_eval.sv */
module usbsx_eval #(
    parameter int BUFFER_BYTES = 512,
    parameter int CNT_W        = 10
) (
    input  usbsx_pkg::t_packet i_pkt,
    input  logic               i_in_message,
    input  logic [CNT_W-1:0]   i_byte_count,
    output usbsx_pkg::t_batch  o_batch,
    output logic               o_in_message,
    output logic [CNT_W-1:0]   o_byte_count
);
    import usbsx_pkg::*;

    logic [7:0]       b_arr [3];
    logic [1:0]       nbytes;
    logic             ends;
    logic [CNT_W-1:0] cnt;
    logic             inm;
    logic [2:0]       k;

    assign b_arr[0] = i_pkt.payload_first;
    assign b_arr[1] = i_pkt.payload_second;
    assign b_arr[2] = i_pkt.payload_third;

    // Decode the code index
    always_comb begin
        case (i_pkt.packet_header[3:0] & CODE_MASK)
            CODE_CONTINUE:  begin nbytes = 2'd3; ends = 1'b0; end
            CODE_END_ONE:   begin nbytes = 2'd1; ends = 1'b1; end
            CODE_END_TWO:   begin nbytes = 2'd2; ends = 1'b1; end
            CODE_END_THREE: begin nbytes = 2'd3; ends = 1'b1; end
            default:        begin nbytes = 2'd0; ends = 1'b0; end
        endcase
    end

    // Walk the carried bytes (up to three), then close the message on an end packet
    always_comb begin
        cnt           = i_byte_count;
        inm           = i_in_message;
        k             = 3'd0;
        o_batch.res   = '0;
        for (int j = 0; j < 3; j++) begin
            if (2'(j) < nbytes) begin
                if (b_arr[j] == BYTE_START) begin
                    cnt = '0;
                    inm = 1'b1;
                end else if (inm && cnt == '0 && b_arr[j] == BYTE_MAKER) begin
                    // skip manufacturer byte at the head of the body
                end else if (b_arr[j] == BYTE_END) begin
                    // skip end byte
                end else if (inm && cnt < CNT_W'(BUFFER_BYTES)) begin
                    o_batch.res[k[1:0]].kind      = KIND_DATA;
                    o_batch.res[k[1:0]].data_byte = b_arr[j][6:0];
                    o_batch.res[k[1:0]].position  = 9'(cnt);
                    k   = k + 3'd1;
                    cnt = cnt + CNT_W'(1);
                end
            end
        end
        if (ends && inm) begin
            inm = 1'b0;
            o_batch.res[k[1:0]].kind           = KIND_COMPLETE;
            o_batch.res[k[1:0]].message_length = 10'(cnt);
            k = k + 3'd1;
        end
        o_batch.n_res = k;
        o_in_message  = inm;
        o_byte_count  = cnt;
    end

endmodule

/* rtl/usb_midi_sysex_reassembler_top.sv */
// Flow: a packet accepted into the input stage is evaluated and loaded into the
// result register, which presents its results (0 to 4) one per cycle while ready
// is high; a new packet loads as the last result of the previous one is taken.
// Reset: synchronous, active low; clears the open-message flag, the byte count,
// the input stage and the result count and index. Ready is high after reset.
module usb_midi_sysex_reassembler_top #(
    parameter int BUFFER_BYTES = 512
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    usbsx_stream_if.sink           i_pkt,
    usbsx_stream_if.source         o_res
);
    import usbsx_pkg::*;

    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);

    t_packet          r_in;
    logic             r_in_vld;
    logic             r_in_message;
    logic [CNT_W-1:0] r_byte_count;
    t_batch           r_batch;
    logic [1:0]       r_idx;

    t_batch           n_batch;
    logic             n_in_message;
    logic [CNT_W-1:0] n_byte_count;

    logic out_valid;
    logic out_last;
    logic drain_done;
    logic load;
    t_result cur;

    usbsx_eval #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .CNT_W        (CNT_W)
    ) u_eval (
        .i_pkt        (r_in),
        .i_in_message (r_in_message),
        .i_byte_count (r_byte_count),
        .o_batch      (n_batch),
        .o_in_message (n_in_message),
        .o_byte_count (n_byte_count)
    );

    // Handshake control
    assign out_valid  = (r_batch.n_res != 3'd0);
    assign out_last   = ({1'b0, r_idx} == (r_batch.n_res - 3'd1));
    assign drain_done = out_valid && o_res.ready && out_last;
    assign load       = r_in_vld && (!out_valid || drain_done);
    assign i_pkt.ready = !r_in_vld || load;

    // Present the current result, flag the final one of its packet
    always_comb begin
        cur      = r_batch.res[r_idx];
        cur.last = out_last;
    end
    assign o_res.valid   = out_valid;
    assign o_res.payload = cur;

    // Capture the incoming request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_pkt.ready) begin
            r_in_vld <= i_pkt.valid;
        end
        if (i_pkt.ready && i_pkt.valid) begin
            r_in <= i_pkt.payload;
        end
    end

    // Advance message state and load or drain the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_message  <= 1'b0;
            r_byte_count  <= '0;
            r_batch.n_res <= 3'd0;
            r_idx         <= 2'd0;
        end else if (load) begin
            r_in_message  <= n_in_message;
            r_byte_count  <= n_byte_count;
            r_batch.n_res <= n_batch.n_res;
            r_idx         <= 2'd0;
        end else if (out_valid && o_res.ready) begin
            if (out_last) begin
                r_batch.n_res <= 3'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
        if (load) begin
            r_batch.res <= n_batch.res;
        end
    end

endmodule

/* rtl/usbsx_checker.sv */
module usbsx_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_res_valid,
    input logic               i_res_ready,
    input usbsx_pkg::t_result i_res
);
    import usbsx_pkg::*;

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res))
        else $error("stalled result changed");

    // A completion always closes the packet's results
    a_complete_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res.kind == KIND_COMPLETE |-> i_res.last)
        else $error("completion not final");

    // Completion carries no byte and no position
    a_complete_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res.kind == KIND_COMPLETE
            |-> i_res.data_byte == 7'd0 && i_res.position == 9'd0)
        else $error("completion has byte fields");

    // Data results in one packet run at consecutive positions; a start byte
    // in the middle of the packet restarts the body at position zero
    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_ready && i_res.kind == KIND_DATA && !i_res.last
            |=> i_res_valid && (i_res.kind == KIND_COMPLETE
                || i_res.position == 9'd0
                || i_res.position == $past(i_res.position) + 9'd1))
        else $error("positions not consecutive");

endmodule

bind usb_midi_sysex_reassembler_top usbsx_checker u_usbsx_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res       (o_res.payload)
);
